// ----- design/atan2qa_pkg.sv -----
package atan2qa_pkg;

    localparam int COORD_W = 16;
    localparam int ANGLE_W = 16;
    // quotient bits out of the divider, one extra bit below the angle LSB for rounding
    localparam int FRAC_W  = ANGLE_W - 1;
    // |x|*|y| reaches 2^(2*COORD_W-2)
    localparam int PROD_W  = 2 * COORD_W - 1;
    localparam int NUM_W   = PROD_W + 1;
    localparam int DEN_W   = PROD_W + 2;
    localparam int B_W     = 16;

    // 0.596227 in Q0.16, rounded to nearest
    localparam logic [B_W-1:0] B_Q16 = 16'd39074;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               zero_vector;
    } t_out;

    // per-word control that rides along the pipeline
    typedef struct packed {
        logic valid;
        logic x_neg;
        logic y_neg;
        logic zero;
    } t_tag;

endpackage

// ----- design/atan2_quadrant_approx.sv -----
// Approximate atan2, fully pipelined: one word accepted every clock, busy is always low.
// The path has 21 register stages: 5 stages of magnitude, multiply and add,
// 15 restoring-divide stages (one quotient bit each), and one output stage for
// rounding and quadrant fixup.
// Synchronous active-low reset clears the valid bits only; data registers are not reset.
// The receiver cannot stall; each result shows for exactly one cycle.
module atan2_quadrant_approx
    import atan2qa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_data,
    output logic o_valid,
    output t_out o_result
);

    // ---------------- stage 1: magnitudes and signs
    t_tag               r_tag1;
    logic [COORD_W-1:0] r_ax1, r_ay1;
    logic [COORD_W-1:0] n_ax1, n_ay1;
    t_tag               n_tag1;

    assign busy = 1'b0;

    always_comb begin
        n_tag1.valid = start;
        n_tag1.x_neg = i_data.x_coord[COORD_W-1];
        n_tag1.y_neg = i_data.y_coord[COORD_W-1];
        n_tag1.zero  = (i_data.x_coord == '0) && (i_data.y_coord == '0);
        n_ax1 = n_tag1.x_neg ? (~i_data.x_coord + 1'b1) : i_data.x_coord;
        n_ay1 = n_tag1.y_neg ? (~i_data.y_coord + 1'b1) : i_data.y_coord;
    end

    // ---------------- stage 2: products
    t_tag              r_tag2;
    logic [PROD_W-1:0] r_pxy2, r_axx2, r_ayy2;

    // ---------------- stage 3: b*|x*y|
    t_tag                  r_tag3;
    logic [PROD_W-1:0]     r_bxy3, r_axx3, r_ayy3;
    logic [PROD_W+B_W-1:0] n_bprod;

    assign n_bprod = r_pxy2 * B_Q16;

    // ---------------- stage 4: numerator and partial denominator
    t_tag             r_tag4;
    logic [NUM_W-1:0] r_num4;
    logic [NUM_W-1:0] r_part4;

    // ---------------- stage 5: denominator
    t_tag             r_tag5;
    logic [NUM_W-1:0] r_num5;
    logic [DEN_W-1:0] r_den5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
            r_tag4.valid <= 1'b0;
            r_tag5.valid <= 1'b0;
        end else begin
            r_tag1.valid <= n_tag1.valid;
            r_tag2.valid <= r_tag1.valid;
            r_tag3.valid <= r_tag2.valid;
            r_tag4.valid <= r_tag3.valid;
            r_tag5.valid <= r_tag4.valid;
        end
        r_tag1.x_neg <= n_tag1.x_neg;
        r_tag1.y_neg <= n_tag1.y_neg;
        r_tag1.zero  <= n_tag1.zero;
        r_ax1 <= n_ax1;
        r_ay1 <= n_ay1;

        r_tag2.x_neg <= r_tag1.x_neg;
        r_tag2.y_neg <= r_tag1.y_neg;
        r_tag2.zero  <= r_tag1.zero;
        r_pxy2 <= PROD_W'(r_ax1 * r_ay1);
        r_axx2 <= PROD_W'(r_ax1 * r_ax1);
        r_ayy2 <= PROD_W'(r_ay1 * r_ay1);

        r_tag3.x_neg <= r_tag2.x_neg;
        r_tag3.y_neg <= r_tag2.y_neg;
        r_tag3.zero  <= r_tag2.zero;
        r_bxy3 <= n_bprod[PROD_W+B_W-1:B_W];
        r_axx3 <= r_axx2;
        r_ayy3 <= r_ayy2;

        r_tag4.x_neg <= r_tag3.x_neg;
        r_tag4.y_neg <= r_tag3.y_neg;
        r_tag4.zero  <= r_tag3.zero;
        r_num4  <= {1'b0, r_bxy3} + {1'b0, r_ayy3};
        r_part4 <= {1'b0, r_axx3} + {1'b0, r_bxy3};

        r_tag5.x_neg <= r_tag4.x_neg;
        r_tag5.y_neg <= r_tag4.y_neg;
        r_tag5.zero  <= r_tag4.zero;
        r_num5 <= r_num4;
        r_den5 <= {1'b0, r_part4} + {1'b0, r_num4};
    end

    // ---------------- divider: one quotient bit per stage
    // Doubling remainder form; when num equals den (x = 0) every bit comes out 1,
    // which rounds to exactly one quarter turn.
    t_tag              r_dtag [FRAC_W+1];
    logic [DEN_W-1:0]  r_rem  [FRAC_W+1];
    logic [DEN_W-1:0]  r_den  [FRAC_W+1];
    logic [FRAC_W-1:0] r_q    [FRAC_W+1];

    always_comb begin
        r_dtag[0] = r_tag5;
        r_rem[0]  = {1'b0, r_num5};
        r_den[0]  = r_den5;
        r_q[0]    = '0;
    end

    for (genvar k = 0; k < FRAC_W; k++) begin : g_div
        logic [DEN_W:0] n_rem2;
        logic [DEN_W:0] n_diff;
        logic           n_bit;

        always_comb begin
            n_rem2 = {r_rem[k], 1'b0};
            n_diff = n_rem2 - {1'b0, r_den[k]};
            n_bit  = (n_rem2 >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dtag[k+1].valid <= 1'b0;
            end else begin
                r_dtag[k+1].valid <= r_dtag[k].valid;
            end
            r_dtag[k+1].x_neg <= r_dtag[k].x_neg;
            r_dtag[k+1].y_neg <= r_dtag[k].y_neg;
            r_dtag[k+1].zero  <= r_dtag[k].zero;
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= n_bit ? n_diff[DEN_W-1:0] : n_rem2[DEN_W-1:0];
            r_q[k+1]   <= {r_q[k][FRAC_W-2:0], n_bit};
        end
    end

    // ---------------- output stage: round, place in quadrant
    t_tag               n_ftag;
    logic [ANGLE_W-1:0] n_r;
    logic [ANGLE_W-1:0] n_base;
    logic [ANGLE_W-1:0] n_angle;
    logic               r_valid;
    t_out               r_result;

    always_comb begin
        n_ftag = r_dtag[FRAC_W];
        // round to nearest, ties up; result lies in [0, quarter]
        n_r    = ANGLE_W'(({1'b0, r_q[FRAC_W]} + 1'b1) >> 1);
        n_base = n_ftag.x_neg ? {1'b1, {(ANGLE_W-1){1'b0}}} : '0;
        if (n_ftag.zero) begin
            n_angle = '0;
        end else if (n_ftag.x_neg != n_ftag.y_neg) begin
            n_angle = n_base - n_r;
        end else begin
            n_angle = n_base + n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_ftag.valid;
        end
        r_result.angle       <= n_angle;
        r_result.zero_vector <= n_ftag.zero;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- dv/atan2_quadrant_checker.sv -----
module atan2_quadrant_checker
    import atan2qa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_in  i_data,
    input  logic o_valid,
    input  t_out o_result,
    output int   err_count,
    output int   pending
);

    t_out angle_q[$];

    // rational atan2 estimate, quadrant-corrected, one turn = 2^ANGLE_W
    function automatic t_out predict_angle(t_in w);
        longint      sx;
        longint      sy;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] bxy;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] r;
        logic [63:0] quarter;
        logic [63:0] acc;
        logic        xn;
        logic        yn;
        t_out        res;

        xn = w.x_coord[COORD_W-1];
        yn = w.y_coord[COORD_W-1];
        sx = w.x_coord;
        sy = w.y_coord;
        ax = xn ? -sx : sx;
        ay = yn ? -sy : sy;
        res = '0;
        if (ax == 0 && ay == 0) begin
            res.zero_vector = 1'b1;
            return res;
        end
        // truncated b*|x|*|y|, b in Q0.16
        bxy = (ax * ay * 64'(B_Q16)) >> 16;
        num = bxy + ay * ay;
        den = ax * ax + bxy + num;
        quarter = 64'd1 << (ANGLE_W - 2);
        if (num >= den) begin
            r = quarter;
        end else begin
            // one extra bit below the LSB, then round half up
            quo = (num << (ANGLE_W - 1)) / den;
            r = (quo + 64'd1) >> 1;
        end
        if (xn) begin
            acc = 64'd2 * quarter;
        end else if (yn) begin
            acc = 64'd4 * quarter;
        end else begin
            acc = 64'd0;
        end
        acc = (xn != yn) ? acc - r : acc + r;
        res.angle = acc[ANGLE_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (start && !busy) begin
                angle_q.push_back(predict_angle(i_data));
            end
            if (o_valid) begin
                if (angle_q.size() == 0) begin
                    $error("result word with no input pending: angle %0d zero_vector %0b",
                           o_result.angle, o_result.zero_vector);
                    err_count++;
                end else begin
                    want = angle_q.pop_front();
                    if (o_result.angle !== want.angle) begin
                        $error("angle: expected %0d, got %0d", want.angle, o_result.angle);
                        err_count++;
                    end
                    if (o_result.zero_vector !== want.zero_vector) begin
                        $error("zero_vector: expected %0b, got %0b",
                               want.zero_vector, o_result.zero_vector);
                        err_count++;
                    end
                end
            end
        end
        pending = angle_q.size();
    end

endmodule

// ----- dv/tb_atan2_quadrant_approx.sv -----
module tb_atan2_quadrant_approx
    import atan2qa_pkg::*;
();

    localparam int N_DIRECTED = 21;
    localparam int N_RANDOM   = 700;
    localparam int N_TAIL     = 100;
    localparam int DRAIN_WAIT = 30;
    localparam int CYCLE_MAX  = 200000;

    int dir_x [N_DIRECTED] = '{0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767,
                               1, -1, -1, 1, 1, -1, 0, 0, -32768, -1, 12345, -30000};
    int dir_y [N_DIRECTED] = '{0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768,
                               1, 1, -1, -1, 0, 0, 1, -1, -1, -32768, -23456, 7};

    int   extremes [6] = '{-32768, -32767, -1, 0, 1, 32767};

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_data;
    logic o_valid;
    t_out o_result;
    int   err_count;
    int   pending;
    int   cycles;
    int   gap_odds;

    atan2_quadrant_approx DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    atan2_quadrant_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_data    (i_data),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .err_count (err_count),
        .pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_in make_vector(int x, int y);
        t_in w;
        w.x_coord = COORD_W'(x);
        w.y_coord = COORD_W'(y);
        return w;
    endfunction

    function automatic t_in random_vector();
        int x;
        int y;
        int m;
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 9))
            5, 6: begin
                x = int'($urandom_range(0, 16)) - 8;
                y = int'($urandom_range(0, 16)) - 8;
            end
            7: begin
                if ($urandom_range(0, 1)) x = 0;
                else y = 0;
            end
            8: begin
                x = extremes[$urandom_range(0, 5)];
                y = extremes[$urandom_range(0, 5)];
            end
            9: begin
                // diagonals: |x| == |y| with random signs
                m = int'($urandom_range(0, 32767));
                x = $urandom_range(0, 1) ? -m : m;
                y = $urandom_range(0, 1) ? -m : m;
            end
            default: ;
        endcase
        return make_vector(x, y);
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(t_in w);
        if (gap_odds > 0 && $urandom_range(1, 100) <= gap_odds) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_data   = '0;
        gap_odds = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_odds = 30;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_word(make_vector(dir_x[i], dir_y[i]));
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // change idle density every 50 words; the tail runs back to back
            if (i >= N_RANDOM - N_TAIL) begin
                gap_odds = 0;
            end else if (i % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0: gap_odds = 0;
                    1: gap_odds = 10;
                    2: gap_odds = 30;
                    default: gap_odds = 60;
                endcase
            end
            send_word(random_vector());
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/atan2qa_pkg.sv
design/atan2_quadrant_approx.sv
dv/atan2_quadrant_checker.sv
dv/tb_atan2_quadrant_approx.sv
